/* rtl/sgb_pkg.sv */
// Shared types, constants and the sequencer microcode for the scaled glyph blitter.
`default_nettype none

package sgb_pkg;

    // Fixed geometry of the glyph and of a result word.
    localparam int GLYPH_SIZE     = 8;
    localparam int MASK_BITS      = 32;
    localparam int RESULT_CAP     = 32;
    localparam int COUNT_W        = $clog2(RESULT_CAP + 1);
    localparam int SCREEN_DIM_MAX = 4096;
    localparam int DIM_W          = 13;
    localparam int Y_W            = 18;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SCREEN_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_SCREEN_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_GLYPH_SCALE   = 2'd2;
    localparam t_cfg_index CFG_DRAW_COLOR    = 2'd3;

    // Payload field types.
    typedef logic [63:0]        t_glyph;
    typedef logic signed [15:0] t_coord;
    typedef logic [11:0]        t_pos;
    typedef logic [23:0]        t_index;
    typedef logic [31:0]        t_mask;

    // Sequencer program addresses.
    typedef logic [2:0] t_step;
    localparam t_step ST_IDLE     = 3'd0;
    localparam t_step ST_SETUP    = 3'd1;
    localparam t_step ST_ROW      = 3'd2;
    localparam t_step ST_EMIT     = 3'd3;
    localparam t_step ST_PUSH     = 3'd4;
    localparam t_step ST_NEXT_SY  = 3'd5;
    localparam t_step ST_NEXT_ROW = 3'd6;
    localparam t_step ST_FLUSH    = 3'd7;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SETUP,
        OP_ROW,
        OP_EMIT,
        OP_PUSH,
        OP_NEXT_SY,
        OP_NEXT_ROW,
        OP_FLUSH
    } t_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_ROW_EMPTY,
        COND_HIDDEN,
        COND_OUT_BUSY,
        COND_SY_MORE,
        COND_ROW_MORE
    } t_cond;

    typedef struct packed {
        logic  accept;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Each step jumps to target when its condition holds and otherwise falls
    // through to the next address. The last step falls through to address zero.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{accept: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: ST_IDLE};
        unique case (s)
            ST_IDLE:     w = '{1'b1, OP_NONE,     COND_NO_INPUT,  ST_IDLE};
            ST_SETUP:    w = '{1'b0, OP_SETUP,    COND_ALWAYS,    ST_ROW};
            ST_ROW:      w = '{1'b0, OP_ROW,      COND_ROW_EMPTY, ST_NEXT_ROW};
            ST_EMIT:     w = '{1'b0, OP_EMIT,     COND_HIDDEN,    ST_NEXT_SY};
            ST_PUSH:     w = '{1'b0, OP_PUSH,     COND_OUT_BUSY,  ST_PUSH};
            ST_NEXT_SY:  w = '{1'b0, OP_NEXT_SY,  COND_SY_MORE,   ST_EMIT};
            ST_NEXT_ROW: w = '{1'b0, OP_NEXT_ROW, COND_ROW_MORE,  ST_ROW};
            ST_FLUSH:    w = '{1'b0, OP_FLUSH,    COND_OUT_BUSY,  ST_FLUSH};
            default:     w = '{1'b0, OP_NONE,     COND_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/sgb_glyph_if.sv */
// Input channel interface: one glyph word per handshake.
`default_nettype none

interface sgb_glyph_if;
    import sgb_pkg::*;

    logic   valid;
    logic   ready;
    t_glyph glyph_bits;
    t_coord origin_x;
    t_coord origin_y;
    logic   last_char;

    modport source (
        output valid, glyph_bits, origin_x, origin_y, last_char,
        input  ready
    );

    modport sink (
        input  valid, glyph_bits, origin_x, origin_y, last_char,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/sgb_row_if.sv */
// Output channel interface: one frame buffer row write per handshake.
`default_nettype none

interface sgb_row_if;
    import sgb_pkg::*;

    logic   valid;
    logic   ready;
    t_pos   row;
    t_pos   first_col;
    t_index pixel_index;
    t_mask  write_mask;
    logic   last_row;

    modport source (
        output valid, row, first_col, pixel_index, write_mask, last_row,
        input  ready
    );

    modport sink (
        input  valid, row, first_col, pixel_index, write_mask, last_row,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/scaled_glyph_blitter_unit.sv */
// Scaled glyph blitter: turns 8x8 glyph words into clipped, scaled row writes.
`default_nettype none

// Each glyph word is drawn at the pen position, magnified by glyph_scale and
// clipped to the screen; every visible row with lit pixels leaves as one row
// write word (row, first column, pixel index, 32-bit mask), the last one of a
// glyph flagged by last_row. The pen is loaded from the origin fields on the
// first glyph of a string and moves right by 8*scale after each glyph.
// A small microprogram steps through the glyph rows, and the output side can
// stall it. One output register and one holding register let the next row be
// prepared while a row write waits to be taken.
module scaled_glyph_blitter_unit #(
    parameter int MAX_SCALE = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  sgb_pkg::t_cfg_index                i_cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sgb_glyph_if.sink                          i_glyph,
    sgb_row_if.source                          o_rows
);
    import sgb_pkg::*;

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int SPAN_W  = $clog2(GLYPH_SIZE * MAX_SCALE + 1);
    localparam int RS_W    = SCALE_W + 3;

    // Configuration.
    logic [DIM_W-1:0] r_screen_width;
    logic [DIM_W-1:0] r_screen_height;
    logic [2:0]       r_glyph_scale;

    // Sequencer and string state.
    t_step            r_step;
    t_step            n_step;
    t_uword           uw;
    logic             r_active;
    logic [15:0]      r_pen_x;
    logic [15:0]      r_pen_y;
    logic [15:0]      n_pen_x;
    t_glyph           r_glyph;
    logic             r_last;

    // Datapath.
    logic [2:0]       r_r;
    logic [SCALE_W-1:0] r_sy;
    logic [Y_W-1:0]   r_y;
    logic [COUNT_W-1:0] r_count;
    logic [MASK_BITS-1:0] r_lane_ok;
    logic [MASK_BITS-1:0] n_lane_ok;
    logic [2:0]       r_lane_k [MASK_BITS];
    logic [2:0]       n_lane_k [MASK_BITS];
    logic [MASK_BITS-1:0] r_row_mask;
    logic [MASK_BITS-1:0] n_row_mask;
    t_pos             r_first;
    logic [14:0]      first_full;
    logic [16:0]      lead_off;
    t_pos             r_new_y;
    logic [24:0]      r_prod;

    // Holding and output registers.
    logic             r_hold_valid;
    t_pos             r_hold_row;
    t_index           r_hold_idx;
    t_mask            r_hold_mask;
    logic             r_out_valid;
    t_pos             r_out_row;
    t_pos             r_out_first;
    t_index           r_out_idx;
    t_mask            r_out_mask;
    logic             r_out_last;

    logic [SCALE_W-1:0] scale;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  thr [GLYPH_SIZE];
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [RS_W-1:0]    row_off;
    logic [7:0]         row_bits;
    logic [16:0]        pen_sum;
    logic               in_acc;
    logic               out_busy;
    logic               out_load;
    logic               visible;
    logic               take;

    always_comb begin
        if (r_glyph_scale == 3'd0) begin
            scale = SCALE_W'(1);
        end else if (32'(r_glyph_scale) > MAX_SCALE) begin
            scale = SCALE_W'(MAX_SCALE);
        end else begin
            scale = SCALE_W'(r_glyph_scale);
        end
    end

    assign span    = SPAN_W'(GLYPH_SIZE) * SPAN_W'(scale);
    assign w_eff   = (r_screen_width > DIM_W'(SCREEN_DIM_MAX)) ? DIM_W'(SCREEN_DIM_MAX)
                                                              : r_screen_width;
    assign h_eff   = (r_screen_height > DIM_W'(SCREEN_DIM_MAX)) ? DIM_W'(SCREEN_DIM_MAX)
                                                               : r_screen_height;
    assign row_off = RS_W'(r_r) * RS_W'(scale);

    // Column thresholds: glyph column k covers offsets k*scale up to (k+1)*scale-1.
    always_comb begin
        for (int j = 0; j < GLYPH_SIZE; j++) begin
            thr[j] = SPAN_W'(j) * SPAN_W'(scale);
        end
    end

    // Per-lane glyph column and visibility, fixed for the whole glyph.
    assign lead_off   = r_pen_x[15] ? (17'd0 - {1'b1, r_pen_x}) : 17'd0;
    assign first_full = r_pen_x[15] ? 15'd0 : r_pen_x[14:0];

    always_comb begin
        logic [16:0] off;
        logic [2:0]  kk;
        for (int i = 0; i < MASK_BITS; i++) begin
            off = lead_off + 17'(i);
            n_lane_ok[i] = (off < 17'(span))
                && ((17'(first_full) + 17'(i)) < 17'(w_eff));
            kk = 3'd0;
            for (int j = 1; j < GLYPH_SIZE; j++) begin
                kk = kk + 3'(17'(thr[j]) <= off);
            end
            n_lane_k[i] = kk;
        end
    end

    // Screen row r takes glyph byte 7-r.
    assign row_bits = r_glyph[{~r_r, 3'b000} +: 8];

    always_comb begin
        for (int i = 0; i < MASK_BITS; i++) begin
            n_row_mask[i] = r_lane_ok[i] & row_bits[r_lane_k[i]];
        end
    end

    assign pen_sum = {r_pen_x[15], r_pen_x} + 17'(span);
    assign n_pen_x = (!pen_sum[16] && pen_sum[15]) ? 16'h7FFF : pen_sum[15:0];

    // Sequencer.
    assign uw       = ucode(r_step);
    assign in_acc   = i_glyph.valid && i_glyph.ready;
    assign out_busy = r_hold_valid && r_out_valid && !o_rows.ready;
    assign out_load = ((uw.op == OP_PUSH) || (uw.op == OP_FLUSH)) && !out_busy
        && r_hold_valid;
    assign visible  = !r_y[Y_W-1] && (r_y[Y_W-2:0] < (Y_W-1)'(h_eff))
        && (r_count != COUNT_W'(RESULT_CAP));

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_NO_INPUT:  take = !i_glyph.valid;
            COND_ROW_EMPTY: take = (n_row_mask == '0);
            COND_HIDDEN:    take = !visible;
            COND_OUT_BUSY:  take = out_busy;
            COND_SY_MORE:   take = (r_sy != SCALE_W'(scale - 1'b1));
            COND_ROW_MORE:  take = (r_r != 3'd7);
            default:        take = 1'b0;
        endcase
    end

    assign n_step = take ? uw.target : t_step'(r_step + 3'd1);

    assign i_glyph.ready = uw.accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= DIM_W'(640);
            r_screen_height <= DIM_W'(480);
            r_glyph_scale   <= 3'd1;
            r_step          <= ST_IDLE;
            r_active        <= 1'b0;
            r_pen_x         <= '0;
            r_pen_y         <= '0;
            r_count         <= '0;
            r_hold_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_step <= n_step;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[DIM_W-1:0];
                    CFG_GLYPH_SCALE:   r_glyph_scale   <= i_cfg_data[2:0];
                    // The draw color is applied by the frame buffer writer.
                    CFG_DRAW_COLOR:    ;
                    default:           ;
                endcase
            end

            if (in_acc) begin
                r_glyph  <= i_glyph.glyph_bits;
                r_last   <= i_glyph.last_char;
                r_active <= 1'b1;
                if (!r_active) begin
                    r_pen_x <= i_glyph.origin_x;
                    r_pen_y <= i_glyph.origin_y;
                end
            end

            // A word moving out of the holding register replaces one being taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rows.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (uw.op)
                OP_SETUP: begin
                    r_lane_ok <= n_lane_ok;
                    r_lane_k  <= n_lane_k;
                    r_first   <= t_pos'(first_full);
                    r_r       <= 3'd0;
                    r_count   <= '0;
                end
                OP_ROW: begin
                    r_row_mask <= n_row_mask;
                    r_y  <= {{(Y_W-16){r_pen_y[15]}}, r_pen_y} + Y_W'(row_off);
                    r_sy <= '0;
                end
                OP_EMIT: begin
                    if (visible) begin
                        r_new_y <= r_y[11:0];
                        r_prod  <= 25'(r_y[11:0]) * 25'(w_eff);
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (!out_busy) begin
                        // The previous row is known not to be the last one.
                        if (r_hold_valid) begin
                            r_out_row   <= r_hold_row;
                            r_out_first <= r_first;
                            r_out_idx   <= r_hold_idx;
                            r_out_mask  <= r_hold_mask;
                            r_out_last  <= 1'b0;
                        end
                        r_hold_valid <= 1'b1;
                        r_hold_row   <= r_new_y;
                        r_hold_idx   <= t_index'(r_prod + 25'(r_first));
                        r_hold_mask  <= r_row_mask;
                    end
                end
                OP_NEXT_SY: begin
                    r_sy <= r_sy + 1'b1;
                    r_y  <= r_y + 1'b1;
                end
                OP_NEXT_ROW: begin
                    r_r <= r_r + 3'd1;
                end
                OP_FLUSH: begin
                    if (!out_busy) begin
                        if (r_hold_valid) begin
                            r_out_row   <= r_hold_row;
                            r_out_first <= r_first;
                            r_out_idx   <= r_hold_idx;
                            r_out_mask  <= r_hold_mask;
                            r_out_last  <= 1'b1;
                        end
                        r_hold_valid <= 1'b0;
                        r_pen_x      <= n_pen_x;
                        if (r_last) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                OP_NONE: ;
                default: ;
            endcase
        end
    end

    assign o_rows.valid       = r_out_valid;
    assign o_rows.row         = r_out_row;
    assign o_rows.first_col   = r_out_first;
    assign o_rows.pixel_index = r_out_idx;
    assign o_rows.write_mask  = r_out_mask;
    assign o_rows.last_row    = r_out_last;

    // A glyph never leaves a row behind in the holding register.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> !r_hold_valid)
        else $error("holding register occupied while waiting for a glyph");

    // The row count of one glyph stays within the result cap.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(RESULT_CAP))
        else $error("row count exceeded the cap");

    // A completed push always leaves a row waiting in the holding register.
    a_push_fills_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_PUSH) && !out_busy) |=> r_hold_valid)
        else $error("push did not fill the holding register");

endmodule

`default_nettype wire

/* test/sgb_row_checker.sv */
// Scoreboard for the scaled glyph blitter: predicts the row writes of each glyph word and checks them.
`timescale 1ns / 1ps

module sgb_row_checker #(
    parameter int MAX_SCALE = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  sgb_pkg::t_cfg_index            i_cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sgb_glyph_if                           i_glyph,
    sgb_row_if                             i_rows,
    output int                             o_mismatches,
    output int                             o_pending
);
    import sgb_pkg::*;

    localparam int COORD_MAX = 32767;

    typedef struct packed {
        t_pos   row;
        t_pos   first_col;
        t_index pixel_index;
        t_mask  write_mask;
        logic   last_row;
    } t_row_write;

    // Register copies as the block holds them.
    logic [DIM_W-1:0] screen_w;
    logic [DIM_W-1:0] screen_h;
    logic [2:0]       scale_reg;
    logic [31:0]      color_reg;   // Never shows up in a row write word.

    // Pen and string state.
    int pen_x;
    int pen_y;
    bit string_open;

    t_row_write expected_rows[$];
    int mismatch_count = 0;
    int rows_waiting = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = rows_waiting;

    task automatic flag_mismatch(input string what);
        $display("%0t ns  MISMATCH  %s", $time, what);
        mismatch_count++;
    endtask

    // Queues every row write that one glyph word produces and moves the pen.
    function automatic void draw_glyph_rows(input t_glyph glyph, input t_coord ox,
                                            input t_coord oy, input logic last);
        int scl;
        int w;
        int h;
        int span;
        int first;
        int off;
        int y;
        int emitted;
        logic [7:0] bits;
        t_mask mask;
        t_row_write wr;

        if (!string_open) begin
            pen_x = ox;
            pen_y = oy;
            string_open = 1'b1;
        end

        scl = int'(scale_reg);
        if (scl < 1) scl = 1;
        if (scl > MAX_SCALE) scl = MAX_SCALE;
        w = (int'(screen_w) > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : int'(screen_w);
        h = (int'(screen_h) > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : int'(screen_h);
        span = GLYPH_SIZE * scl;
        first = (pen_x < 0) ? 0 : pen_x;
        emitted = 0;

        for (int r = 0; r < GLYPH_SIZE; r++) begin
            // The top screen row comes from the most significant byte.
            bits = glyph[8 * (7 - r) +: 8];
            if (bits == 8'h00) continue;
            mask = '0;
            for (int i = 0; i < MASK_BITS; i++) begin
                off = first + i - pen_x;
                if (off >= span || first + i >= w) break;
                if (bits[off / scl]) mask[i] = 1'b1;
            end
            if (mask == '0) continue;
            for (int sy = 0; sy < scl; sy++) begin
                y = pen_y + r * scl + sy;
                if (y < 0 || y >= h) continue;
                if (emitted >= RESULT_CAP) break;
                wr.row         = t_pos'(y);
                wr.first_col   = t_pos'(first);
                wr.pixel_index = t_index'(y * w + first);
                wr.write_mask  = mask;
                wr.last_row    = 1'b0;
                expected_rows.push_back(wr);
                emitted++;
            end
        end
        if (emitted > 0) expected_rows[expected_rows.size() - 1].last_row = 1'b1;

        pen_x += span;
        if (pen_x > COORD_MAX) pen_x = COORD_MAX;
        if (last) string_open = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_row_write want;
        if (!i_rst_n) begin
            screen_w    = 13'd640;
            screen_h    = 13'd480;
            scale_reg   = 3'd1;
            color_reg   = 32'hFFFF_FFFF;
            pen_x       = 0;
            pen_y       = 0;
            string_open = 1'b0;
            expected_rows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  screen_w  = i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: screen_h  = i_cfg_data[DIM_W-1:0];
                    CFG_GLYPH_SCALE:   scale_reg = i_cfg_data[2:0];
                    CFG_DRAW_COLOR:    color_reg = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_glyph.valid && i_glyph.ready) begin
                draw_glyph_rows(i_glyph.glyph_bits, i_glyph.origin_x, i_glyph.origin_y,
                                i_glyph.last_char);
            end
            if (i_rows.valid && i_rows.ready) begin
                if (expected_rows.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: row %0d col %0d mask %h",
                                            i_rows.row, i_rows.first_col, i_rows.write_mask));
                end else begin
                    want = expected_rows.pop_front();
                    if (i_rows.row !== want.row)
                        flag_mismatch($sformatf("row: got %0d, expected %0d",
                                                i_rows.row, want.row));
                    if (i_rows.first_col !== want.first_col)
                        flag_mismatch($sformatf("first_col: got %0d, expected %0d (row %0d)",
                                                i_rows.first_col, want.first_col, want.row));
                    if (i_rows.pixel_index !== want.pixel_index)
                        flag_mismatch($sformatf("pixel_index: got %0d, expected %0d (row %0d)",
                                                i_rows.pixel_index, want.pixel_index, want.row));
                    if (i_rows.write_mask !== want.write_mask)
                        flag_mismatch($sformatf("write_mask: got %h, expected %h (row %0d)",
                                                i_rows.write_mask, want.write_mask, want.row));
                    if (i_rows.last_row !== want.last_row)
                        flag_mismatch($sformatf("last_row: got %b, expected %b (row %0d)",
                                                i_rows.last_row, want.last_row, want.row));
                end
            end
        end
        rows_waiting = expected_rows.size();
    end

endmodule

/* test/tb_scaled_glyph_blitter_unit.sv */
// Testbench top for the scaled glyph blitter: clock, reset, glyph stimulus and the verdict.
`timescale 1ns / 1ps

module tb_scaled_glyph_blitter_unit;
    import sgb_pkg::*;

    localparam int MAX_SCALE       = 4;
    localparam int SETTLE_CYCLES   = 160;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_index            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int mismatches;
    int pending;
    int stall_cycles;
    int cur_w;
    int cur_h;
    bit steady;   // Set for a stretch in which neither side idles.

    sgb_glyph_if glyph_ch();
    sgb_row_if   row_ch();

    scaled_glyph_blitter_unit #(
        .MAX_SCALE(MAX_SCALE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_glyph    (glyph_ch),
        .o_rows     (row_ch)
    );

    sgb_row_checker #(
        .MAX_SCALE(MAX_SCALE)
    ) row_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_glyph     (glyph_ch),
        .i_rows      (row_ch),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // Presents one glyph word and returns at the edge that takes it; valid stays high.
    task automatic send_glyph(input t_glyph g, input int ox, input int oy, input logic last);
        while (!steady && $urandom_range(99) < 9) begin
            glyph_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        glyph_ch.valid      <= 1'b1;
        glyph_ch.glyph_bits <= g;
        glyph_ch.origin_x   <= t_coord'(ox);
        glyph_ch.origin_y   <= t_coord'(oy);
        glyph_ch.last_char  <= last;
        @(posedge i_clk);
        while (!glyph_ch.ready) @(posedge i_clk);
    endtask

    // Stops sending, waits for every expected word, then lets a blank glyph finish.
    task automatic settle();
        glyph_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_screen(input int w, input int h, input int s, input logic [31:0] color);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= 32'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= 32'(h);
        @(posedge i_clk);
        i_cfg_index <= CFG_GLYPH_SCALE;
        i_cfg_data  <= 32'(s);
        @(posedge i_clk);
        i_cfg_index <= CFG_DRAW_COLOR;
        i_cfg_data  <= color;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_w = ((w & 8191) > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : (w & 8191);
        cur_h = ((h & 8191) > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : (h & 8191);
    endtask

    function automatic t_glyph pick_glyph();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) return '0;
        if (sel < 22) return t_glyph'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
        if (sel < 32) return '1;
        if (sel < 45) return {$urandom, $urandom} & {$urandom, $urandom};
        return {$urandom, $urandom};
    endfunction

    // Output side: random stalls except during the steady stretch.
    initial begin
        row_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            row_ch.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (glyph_ch.valid && glyph_ch.ready) || (row_ch.valid && row_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        int sel;
        int ox;
        int oy;

        glyph_ch.valid      <= 1'b0;
        glyph_ch.glyph_bits <= '0;
        glyph_ch.origin_x   <= '0;
        glyph_ch.origin_y   <= '0;
        glyph_ch.last_char  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        steady      <= 1'b0;
        cur_w = 640;
        cur_h = 480;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset screen at unit scale: clipping on every side, blank character, origins
        // ignored inside a string, and a pen that runs into the coordinate ceiling.
        send_glyph('1, 0, 0, 1'b1);
        send_glyph(64'h8142_2418_1824_4281, -5, 10, 1'b1);
        send_glyph('0, 100, 100, 1'b0);
        send_glyph(64'h0000_0000_0000_00FF, -1, -1, 1'b1);
        send_glyph(64'hFF00_0000_0000_0000, 636, 476, 1'b1);
        send_glyph('1, 10, -3, 1'b1);
        send_glyph('1, 32767, 32767, 1'b1);
        send_glyph('1, -32768, -32768, 1'b1);
        send_glyph(64'hAAAA_5555_AAAA_5555, 32750, 0, 1'b0);
        send_glyph(64'h5555_AAAA_5555_AAAA, 0, 0, 1'b0);
        send_glyph('1, 0, 0, 1'b1);
        settle();

        // Largest scale: a full glyph fills all 32 mask bits on 32 lines.
        program_screen(8191, 4096, MAX_SCALE, 32'h0);
        send_glyph('1, 0, 0, 1'b1);
        send_glyph(64'h0102_0408_1020_4080, -7, 4090, 1'b1);
        send_glyph('1, 4080, 0, 1'b1);
        settle();

        // Zero width screen and scale zero.
        program_screen(0, 100, 0, 32'hFFFF_FFFF);
        send_glyph('1, 0, 0, 1'b1);
        settle();

        // Scale above the maximum on a one line screen.
        program_screen(33, 1, 7, 32'h1234_5678);
        send_glyph('1, 1, 0, 1'b0);
        send_glyph(64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 1'b1);
        settle();

        program_screen(8191, 8191, 5, 32'h8000_0001);
        send_glyph(64'h00FF_00FF_00FF_00FF, 4095, 4095, 1'b1);
        settle();

        program_screen(1, 4096, 2, 32'h0F0F_0F0F);
        send_glyph(64'h0101_0101_0101_0101, 0, 0, 1'b1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: program_screen(640, 480, 1, $urandom);
                1: program_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                                  $urandom_range(1, MAX_SCALE), $urandom);
                2: program_screen($urandom_range(1, 48), $urandom_range(1, 48),
                                  $urandom_range(0, 7), 32'h0);
                3: program_screen($urandom_range(4096, 8191), $urandom_range(4096, 8191),
                                  MAX_SCALE, 32'hFFFF_FFFF);
                4: program_screen($urandom_range(0, 8191), $urandom_range(0, 8191),
                                  $urandom_range(0, 7), $urandom);
                default: program_screen(320, 200, 2, $urandom);
            endcase
            steady <= (p == 3);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                len = $urandom_range(1, 6);
                sel = $urandom_range(99);
                if (sel < 75) begin
                    ox = int'($urandom_range(0, cur_w + 40)) - 40;
                    oy = int'($urandom_range(0, cur_h + 40)) - 40;
                end else if (sel < 90) begin
                    ox = $urandom;
                    oy = $urandom;
                end else begin
                    ox = 32767 - int'($urandom_range(0, 100));
                    oy = int'($urandom_range(0, cur_h));
                end
                for (int c = 0; c < len; c++) begin
                    send_glyph(pick_glyph(), ox, oy, c == len - 1);
                    sent++;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
